@@ src/ole_pkg.sv @@
// Package for the ordered list engine: sizes, codes, word types and the
// command that the control broadcasts to the row of entry cells.
// Used by every module of the block; depends on nothing.
package ole_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef enum logic [3:0] {
    OP_ADD_HEAD   = 4'd0,
    OP_ADD_TAIL   = 4'd1,
    OP_REM_HEAD   = 4'd2,
    OP_REM_TAIL   = 4'd3,
    OP_CLEAR      = 4'd4,
    OP_REM_BEFORE = 4'd5,
    OP_REM_AFTER  = 4'd6,
    OP_INS_POS    = 4'd7,
    OP_REM_POS    = 4'd8,
    OP_INS_BEFORE = 4'd9,
    OP_INS_AFTER  = 4'd10,
    OP_DEDUP      = 4'd11,
    OP_REM_ALL    = 4'd12,
    OP_REVERSE    = 4'd13,
    OP_DUMP       = 4'd14
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_NOTF  = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_REV,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    A_NONE,
    A_KEEP,
    A_DROP,
    A_INS
  } act_e;

  typedef struct packed {
    logic [3:0]         op;
    logic signed [31:0] data_value;
    logic signed [31:0] match_value;
    logic [5:0]         position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [5:0]         list_count;
    logic signed [31:0] element;
    logic               element_valid;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic               shift;
    logic               wr;
    logic [IDX_W-1:0]   m;
    logic signed [31:0] wval;
  } cell_cmd_t;

endpackage

@@ src/ordered_list_engine.sv @@
// Top level of the ordered list engine: control sequencer, output register
// and the row of entry cells. Depends on ole_pkg and ole_cell.
//
// Usage: one input word per operation on in_word_i, taken when in_valid_i is
// high and in_stall_o is low. Results leave on out_word_o with out_valid_o;
// the receiver holds a result with out_stall_i. Every operation gives one
// result word, except a dump of a non-empty list, which gives one word per
// entry from head to tail; last marks the final word of an operation.
// The list lives in a row of cells, entry 0 at the head. Most operations
// walk the list once: each cycle the head entry is rotated to the tail,
// dropped, or a new value is written at the tail; a dump waits while the
// output is held. Reverse rotates entries in a pass of its own. Duplicate
// removal runs one full walk per kept entry. Remove tail, clear and
// operations refused at acceptance go straight to the result.
// The block takes one operation at a time; in_stall_o is high from the
// cycle after acceptance until the result is in the output register, and
// a stalled receiver holds the walk of a dump and the final result.
// Reset empties the list and clears the output valid; no clearing pass.
module ordered_list_engine import ole_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic signed [31:0] data_q, data_d, match_q, match_d, key_q, key_d;
  logic [CNT_W-1:0]   p_q, p_d, len_q, len_d, k_q, k_d, o_q, o_d, cnt_q, cnt_d;
  logic               found_q, found_d, pend_q, pend_d, rem_q, rem_d;
  status_e            st_q, st_d;
  out_word_t          out_q, out_d;
  logic               out_vld_q, out_vld_d;

  act_e               act;
  cell_cmd_t          cmd;
  logic               out_free, at_end, emit;
  logic signed [31:0] vals [CAPACITY];
  logic signed [31:0] head, nxt;
  logic [CNT_W-1:0]   n, pos;
  op_e                in_op;

  assign head     = vals[0];
  assign nxt      = vals[1];
  assign out_free = !out_vld_q || !out_stall_i;
  assign at_end   = (k_q == len_q);
  assign n        = cnt_q;
  assign pos      = CNT_W'(in_word_i.position);
  assign in_op    = op_e'(in_word_i.op);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] right;
    if (i == CAPACITY - 1) begin : g_last
      assign right = vals[i];
    end else begin : g_mid
      assign right = vals[i+1];
    end
    ole_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .cmd_i   (cmd),
      .right_i (right),
      .val_o   (vals[i])
    );
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    data_d    = data_q;
    match_d   = match_q;
    key_d     = key_q;
    p_d       = p_q;
    len_d     = len_q;
    k_d       = k_q;
    o_d       = o_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    pend_d    = pend_q;
    rem_d     = rem_q;
    st_d      = st_q;
    act       = A_NONE;
    emit      = 1'b0;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    cmd.shift = 1'b0;
    cmd.wr    = 1'b0;
    cmd.m     = IDX_W'(cnt_q - 1'b1);
    cmd.wval  = head;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_op;
          data_d  = in_word_i.data_value;
          match_d = in_word_i.match_value;
          len_d   = n;
          k_d     = '0;
          o_d     = '0;
          p_d     = '0;
          found_d = 1'b0;
          pend_d  = 1'b0;
          rem_d   = 1'b0;
          st_d    = ST_DONE;
          state_d = S_WALK;
          if ((in_op == OP_ADD_HEAD || in_op == OP_ADD_TAIL || in_op == OP_INS_POS ||
               in_op == OP_INS_BEFORE || in_op == OP_INS_AFTER) && n >= CNT_W'(CAPACITY)) begin
            st_d    = ST_FULL;
            state_d = S_RESP;
          end else begin
            unique case (in_op)
              OP_ADD_HEAD: p_d = '0;
              OP_ADD_TAIL: p_d = n;
              OP_INS_POS: begin
                p_d = pos;
                if (pos > n) begin
                  st_d    = ST_NOTF;
                  state_d = S_RESP;
                end
              end
              OP_REM_HEAD: begin
                if (n == '0) begin
                  st_d    = ST_NOTF;
                  state_d = S_RESP;
                end
              end
              OP_REM_TAIL: begin
                state_d = S_RESP;
                if (n == '0) begin
                  st_d = ST_NOTF;
                end else begin
                  cnt_d = n - 1'b1;
                end
              end
              OP_REM_POS: begin
                p_d = pos;
                if (pos >= n) begin
                  st_d    = ST_NOTF;
                  state_d = S_RESP;
                end
              end
              OP_CLEAR: begin
                cnt_d   = '0;
                state_d = S_RESP;
              end
              OP_REM_BEFORE, OP_REM_AFTER, OP_INS_BEFORE, OP_INS_AFTER, OP_REM_ALL,
              OP_DUMP: begin
                if (n == '0) begin
                  st_d    = ST_NOTF;
                  state_d = S_RESP;
                end
              end
              OP_DEDUP: state_d = S_WALK;
              OP_REVERSE: state_d = S_REV;
              default: begin
                st_d    = ST_NOTF;
                state_d = S_RESP;
              end
            endcase
          end
        end
      end

      S_WALK: begin
        if (op_q == OP_DEDUP) begin
          if (!at_end) begin
            if (k_q < o_q) begin
              act = A_KEEP;
            end else if (k_q == o_q) begin
              key_d = head;
              act   = A_KEEP;
            end else if (head == key_q) begin
              act = A_DROP;
            end else begin
              act = A_KEEP;
            end
          end else begin
            o_d = o_q + 1'b1;
            k_d = '0;
            len_d = cnt_q;
            if (o_q + 1'b1 >= cnt_q) begin
              state_d = S_RESP;
            end
          end
        end else if (op_q == OP_DUMP) begin
          if (at_end) begin
            state_d = S_IDLE;
          end else if (out_free) begin
            act  = A_KEEP;
            emit = 1'b1;
          end
        end else begin
          priority case (op_q)
            OP_ADD_HEAD, OP_ADD_TAIL, OP_INS_POS: begin
              if (k_q == p_q && !found_q) begin
                act     = A_INS;
                found_d = 1'b1;
              end else if (!at_end) begin
                act = A_KEEP;
              end
            end
            OP_REM_HEAD, OP_REM_POS: begin
              if (!at_end) begin
                act = (k_q == p_q) ? A_DROP : A_KEEP;
              end
            end
            OP_REM_BEFORE: begin
              if (!at_end) begin
                if (!found_q && (k_q + 1'b1 < len_q) && nxt == match_q) begin
                  act     = A_DROP;
                  found_d = 1'b1;
                  rem_d   = 1'b1;
                end else begin
                  act = A_KEEP;
                end
              end
            end
            OP_REM_AFTER: begin
              if (!at_end) begin
                if (pend_q) begin
                  act    = A_DROP;
                  pend_d = 1'b0;
                  rem_d  = 1'b1;
                end else if (!found_q && head == match_q) begin
                  act     = A_KEEP;
                  found_d = 1'b1;
                  pend_d  = 1'b1;
                end else begin
                  act = A_KEEP;
                end
              end
            end
            OP_INS_BEFORE: begin
              if (!at_end) begin
                if (!found_q && head == match_q) begin
                  act     = A_INS;
                  found_d = 1'b1;
                end else begin
                  act = A_KEEP;
                end
              end
            end
            OP_INS_AFTER: begin
              if (pend_q) begin
                act    = A_INS;
                pend_d = 1'b0;
              end else if (!at_end) begin
                act = A_KEEP;
                if (!found_q && head == match_q) begin
                  found_d = 1'b1;
                  pend_d  = 1'b1;
                end
              end
            end
            OP_REM_ALL: begin
              if (!at_end) begin
                if (head == match_q) begin
                  act   = A_DROP;
                  rem_d = 1'b1;
                end else begin
                  act = A_KEEP;
                end
              end
            end
            default: act = A_NONE;
          endcase
          if (at_end && act == A_NONE) begin
            state_d = S_RESP;
            priority case (op_q)
              OP_REM_BEFORE, OP_REM_AFTER, OP_REM_ALL: st_d = rem_q ? ST_DONE : ST_NOTF;
              OP_INS_BEFORE, OP_INS_AFTER: st_d = found_q ? ST_DONE : ST_NOTF;
              default: st_d = ST_DONE;
            endcase
          end
        end
      end

      S_REV: begin
        if (k_q + 1'b1 < len_q) begin
          cmd.shift = 1'b1;
          cmd.wr    = 1'b1;
          cmd.m     = IDX_W'(len_q - 1'b1 - k_q);
          k_d       = k_q + 1'b1;
        end else begin
          st_d    = ST_DONE;
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_d.status        = st_q;
          out_d.list_count    = 6'(cnt_q);
          out_d.element       = '0;
          out_d.element_valid = 1'b0;
          out_d.last          = 1'b1;
          out_vld_d           = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    unique case (act)
      A_KEEP: begin
        cmd.shift = 1'b1;
        cmd.wr    = 1'b1;
        k_d       = k_q + 1'b1;
      end
      A_DROP: begin
        cmd.shift = 1'b1;
        cnt_d     = cnt_q - 1'b1;
        k_d       = k_q + 1'b1;
      end
      A_INS: begin
        cmd.wr   = 1'b1;
        cmd.m    = IDX_W'(cnt_q);
        cmd.wval = data_q;
        cnt_d    = cnt_q + 1'b1;
      end
      default: ;
    endcase

    if (emit) begin
      out_d.status        = ST_DONE;
      out_d.list_count    = 6'(cnt_q);
      out_d.element       = head;
      out_d.element_valid = 1'b1;
      out_d.last          = (k_q + 1'b1 == len_q);
      out_vld_d           = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    data_q  <= data_d;
    match_q <= match_d;
    key_q   <= key_d;
    p_q     <= p_d;
    len_q   <= len_d;
    k_q     <= k_d;
    o_q     <= o_d;
    found_q <= found_d;
    pend_q  <= pend_d;
    rem_q   <= rem_d;
    st_q    <= st_d;
    out_q   <= out_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("engine took a word without going busy");

  a_resp_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP) |=> $stable(cnt_q))
    else $error("count changed while the result waited");

  a_element_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.element_valid) |-> (out_word_o.status == ST_DONE))
    else $error("dump word carries a failure status");

endmodule

@@ src/ole_cell.sv @@
// One entry cell of the list row: holds one value and takes its right
// neighbor's value or the broadcast value as the control commands.
// Depends on ole_pkg.
module ole_cell import ole_pkg::*; (
  input  logic               clk_i,
  input  logic [IDX_W-1:0]   idx_i,
  input  cell_cmd_t          cmd_i,
  input  logic signed [31:0] right_i,
  output logic signed [31:0] val_o
);

  logic signed [31:0] val_q, val_d;

  always_comb begin
    if (cmd_i.shift && (idx_i < cmd_i.m)) begin
      val_d = right_i;
    end else if (cmd_i.wr && (idx_i == cmd_i.m)) begin
      val_d = cmd_i.wval;
    end else begin
      val_d = val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule
